>>> rtl/i2c_master_bit_sequencer_core_macros.svh
// Assertion macros for the I2C master bit sequencer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define I2CMBS_ASSERT_IMP(lbl, clk, rstn, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define I2CMBS_ASSERT_NXT(lbl, clk, rstn, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error(msg);

`else

`define I2CMBS_ASSERT_IMP(lbl, clk, rstn, cond, expr, msg)
`define I2CMBS_ASSERT_NXT(lbl, clk, rstn, cond, expr, msg)

`endif

`endif

>>> rtl/i2cmbs_pkg.sv
// Shared types, codes and constants of the I2C master bit sequencer.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps

package i2cmbs_pkg;

    localparam int BUF_DEPTH = 16;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // operation codes
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_BEGIN_WRITE = 3'd1;
    localparam logic [2:0] OP_BEGIN_READ  = 3'd2;
    localparam logic [2:0] OP_LOAD        = 3'd3;
    localparam logic [2:0] OP_ABORT       = 3'd4;

    // frame kinds
    localparam logic [1:0] FRAME_FIRST      = 2'd0;
    localparam logic [1:0] FRAME_NEXT       = 2'd1;
    localparam logic [1:0] FRAME_LAST       = 2'd2;
    localparam logic [1:0] FRAME_FIRST_LAST = 2'd3;

    // event codes
    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_WRITTEN   = 2'd1;
    localparam logic [1:0] EV_AVAILABLE = 2'd2;
    localparam logic [1:0] EV_NACK      = 2'd3;

    typedef enum logic [13:0] {
        PH_IDLE             = 14'b00000000000001,
        PH_RESTART_SCL_HIGH = 14'b00000000000010,
        PH_START_SDA_LOW    = 14'b00000000000100,
        PH_START_SCL_LOW    = 14'b00000000001000,
        PH_WR_SCL_HIGH      = 14'b00000000010000,
        PH_WR_SCL_LOW       = 14'b00000000100000,
        PH_RD_SCL_HIGH      = 14'b00000001000000,
        PH_RD_SCL_LOW       = 14'b00000010000000,
        PH_ACKCHK_SCL_HIGH  = 14'b00000100000000,
        PH_ACKCHK_SCL_LOW   = 14'b00001000000000,
        PH_ACKGEN_SCL_HIGH  = 14'b00010000000000,
        PH_ACKGEN_SCL_LOW   = 14'b00100000000000,
        PH_STOP_SCL_HIGH    = 14'b01000000000000,
        PH_STOP_SDA_HIGH    = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  bit_pos;
        logic [7:0]  shift_byte;
        logic [4:0]  byte_pos;
        logic [4:0]  xfer_len;
        logic        sending_addr;
        logic [1:0]  cur_frame;
        logic [1:0]  prev_frame;
        logic        prev_was_write;
        logic        reading;
        logic        ack_sampled;
        logic        nack_seen;
        logic        scl;
        logic        sda;
    } seq_state_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [1:0] frame_kind;
        logic [4:0] byte_count;
        logic [3:0] load_index;
        logic [7:0] load_value;
        logic       sda_sample;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic [1:0] event_code;
        logic       read_valid;
        logic [3:0] read_index;
        logic [7:0] read_value;
    } result_t;

    localparam seq_state_t SEQ_RESET = '{
        phase:          PH_IDLE,
        bit_pos:        3'd7,
        shift_byte:     8'd0,
        byte_pos:       5'd0,
        xfer_len:       5'd0,
        sending_addr:   1'b0,
        cur_frame:      FRAME_FIRST_LAST,
        prev_frame:     FRAME_FIRST_LAST,
        prev_was_write: 1'b0,
        reading:        1'b0,
        ack_sampled:    1'b0,
        nack_seen:      1'b0,
        scl:            1'b1,
        sda:            1'b1
    };

endpackage

>>> rtl/i2c_master_bit_sequencer_core.sv
// I2C master bit sequencer top level: input register, sequencer state, result register.
// Depends on i2cmbs_pkg, i2cmbs_store, i2cmbs_step and the assertion macro header.
`timescale 1ns / 1ps
// Usage
//   s_ channel: one command beat per bus phase. tuser carries the operation
//   (tick, begin write, begin read, load write byte, abort); tdata carries the
//   frame kind, byte count, load slot and value and the sampled SDA level.
//   m_ channel: exactly one result beat per command beat, in order, with the
//   SCL and SDA drive levels, busy flag, read byte if one completed, and the
//   event code (written, data available, NACK error) in tuser.
//   APB port: register 0 at byte address 0 holds the 7-bit target address;
//   write it only while the sequencer is idle.
// Timing
//   A beat is taken into the input register, then updates the state and lands
//   in the result register when that register is empty or being read out. The
//   state update is one combinational pass, so one beat per cycle is sustained
//   while m_tready stays high.
// Reset and back-pressure
//   aresetn (synchronous, low) idles the sequencer with both lines released
//   and clears the address register; the write buffer keeps its contents.
//   When m_tready is low the result register holds; one further beat waits in
//   the input register, after which s_tready drops.

module i2c_master_bit_sequencer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // frame_kind[1:0], byte_count[6:2], load_index[10:7],
                                   // load_value[18:11], sda_sample[19], zero pad [23:20]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_level[0], sda_level[1], busy_res[2], read_valid[3],
                                   // read_index[7:4], read_value[15:8]
    output logic [1:0]  m_tuser,   // event_code[1:0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cmbs_pkg::*;

    `include "i2c_master_bit_sequencer_core_macros.svh"

    logic       in_valid_reg;
    logic       in_valid_next;
    item_t      item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    result_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    logic [6:0] target_address_reg;
    logic [6:0] target_address_next;

    result_t    result_next;
    logic       s_accept;
    logic       advance;
    logic       cfg_write;
    logic [4:0] store_pos;
    logic [7:0] store_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {25'd0, target_address_reg} : 32'd0;

    assign s_accept = s_tvalid && s_tready;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next       = s_accept || (in_valid_reg && !advance);
        out_valid_next      = advance || (out_valid_reg && !m_tready);
        target_address_next = cfg_write ? pwdata[6:0] : target_address_reg;
    end

    i2cmbs_store u_store (
        .aclk     (aclk),
        .wr_en    (advance && (item_reg.operation == OP_LOAD)),
        .wr_index (item_reg.load_index),
        .wr_value (item_reg.load_value),
        .rd_pos   (store_pos),
        .rd_data  (store_data)
    );

    i2cmbs_step u_step (
        .state_cur      (state_reg),
        .item           (item_reg),
        .target_address (target_address_reg),
        .store_data     (store_data),
        .store_pos      (store_pos),
        .state_next     (state_next),
        .result         (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            state_reg          <= SEQ_RESET;
            target_address_reg <= 7'd0;
        end else begin
            in_valid_reg       <= in_valid_next;
            out_valid_reg      <= out_valid_next;
            target_address_reg <= target_address_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= '{
                operation:  s_tuser,
                frame_kind: s_tdata[1:0],
                byte_count: s_tdata[6:2],
                load_index: s_tdata[10:7],
                load_value: s_tdata[18:11],
                sda_sample: s_tdata[19]
            };
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.read_value, result_reg.read_index, result_reg.read_valid,
                       result_reg.busy_res, result_reg.sda_level, result_reg.scl_level};
    assign m_tuser  = result_reg.event_code;

    // checks
    `I2CMBS_ASSERT_IMP(a_idle_clean, aclk, aresetn, state_reg.phase == PH_IDLE, (state_reg.bit_pos == 3'd7) && !state_reg.sending_addr, "idle with bit counter or address flag left set")
    `I2CMBS_ASSERT_NXT(a_advance_lands, aclk, aresetn, advance, out_valid_reg, "advanced beat did not reach the result register")
    `I2CMBS_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_tready, in_valid_reg && out_valid_reg && !m_tready, "input stalled without a blocked result")
    `I2CMBS_ASSERT_IMP(a_read_fields_clear, aclk, aresetn, out_valid_reg && !result_reg.read_valid, (result_reg.read_index == 4'd0) && (result_reg.read_value == 8'd0), "read fields set without a read byte")
    `I2CMBS_ASSERT_IMP(a_busy_matches, aclk, aresetn, advance, result_next.busy_res == (state_next.phase != PH_IDLE), "busy flag disagrees with next phase")

endmodule

>>> rtl/i2cmbs_store.sv
// Write byte buffer: loaded one slot per beat, read at the current byte position.
// Depends on i2cmbs_pkg.
`timescale 1ns / 1ps

module i2cmbs_store (
    input  logic       aclk,
    input  logic       wr_en,
    input  logic [3:0] wr_index,
    input  logic [7:0] wr_value,
    input  logic [4:0] rd_pos,
    output logic [7:0] rd_data
);
    import i2cmbs_pkg::*;

    logic [7:0] store_reg [BUF_DEPTH];
    logic       wr_in_range;

    // byte position folded onto the buffer depth (small constant table)
    function automatic logic [BUF_AW-1:0] slot_of(input logic [4:0] pos);
        logic [BUF_AW-1:0] slot;
        slot = '0;
        for (int i = 0; i < 32; i++) begin
            if (pos == 5'(i)) begin
                slot = BUF_AW'(i % BUF_DEPTH);
            end
        end
        return slot;
    endfunction

    assign wr_in_range = (32'(wr_index) < BUF_DEPTH);

    always_ff @(posedge aclk) begin
        if (wr_en && wr_in_range) begin
            store_reg[BUF_AW'(wr_index)] <= wr_value;
        end
    end

    assign rd_data = store_reg[slot_of(rd_pos)];

endmodule

>>> rtl/i2cmbs_step.sv
// Next-state and result logic: advances the bus sequencer by one beat.
// Depends on i2cmbs_pkg; the buffer read comes from i2cmbs_store.
`timescale 1ns / 1ps

module i2cmbs_step (
    input  i2cmbs_pkg::seq_state_t state_cur,
    input  i2cmbs_pkg::item_t      item,
    input  logic [6:0]             target_address,
    input  logic [7:0]             store_data,
    output logic [4:0]             store_pos,
    output i2cmbs_pkg::seq_state_t state_next,
    output i2cmbs_pkg::result_t    result
);
    import i2cmbs_pkg::*;

    seq_state_t s;
    logic [1:0] ev;
    logic       rv;
    logic [3:0] ri;
    logic [7:0] rval;
    logic [4:0] bp_inc;
    logic [5:0] bp_inc_wide;
    logic       is_begin;
    logic       ack_low;
    logic       is_read;
    logic       first;
    logic       restart;
    logic       last_frame;

    assign bp_inc      = state_cur.byte_pos + 5'd1;
    assign bp_inc_wide = {1'b0, state_cur.byte_pos} + 6'd1;
    assign is_begin    = (item.operation == OP_BEGIN_WRITE) ||
                         (item.operation == OP_BEGIN_READ);
    assign ack_low     = (state_cur.phase == PH_ACKCHK_SCL_LOW) ||
                         (state_cur.phase == PH_ACKGEN_SCL_LOW);
    assign is_read     = (item.operation == OP_BEGIN_READ);
    assign first       = item.frame_kind inside {FRAME_FIRST, FRAME_FIRST_LAST};
    assign restart     = is_read && state_cur.prev_was_write &&
                         (state_cur.prev_frame inside {FRAME_FIRST, FRAME_NEXT});
    assign last_frame  = state_cur.cur_frame inside {FRAME_LAST, FRAME_FIRST_LAST};

    // a new data byte after an acknowledge is fetched at the advanced position
    always_comb begin
        if (is_begin) begin
            store_pos = 5'd0;
        end else if (ack_low && !state_cur.sending_addr) begin
            store_pos = bp_inc;
        end else begin
            store_pos = state_cur.byte_pos;
        end
    end

    always_comb begin
        s    = state_cur;
        ev   = EV_NONE;
        rv   = 1'b0;
        ri   = 4'd0;
        rval = 8'd0;
        case (item.operation)
            OP_TICK: begin
                case (state_cur.phase)
                    PH_RESTART_SCL_HIGH: begin
                        s.scl   = 1'b1;
                        s.phase = PH_START_SDA_LOW;
                    end
                    PH_START_SDA_LOW: begin
                        s.sda   = 1'b0;
                        s.phase = PH_START_SCL_LOW;
                    end
                    PH_START_SCL_LOW: begin
                        s.scl = 1'b0;
                        if (!s.sending_addr) begin
                            s.shift_byte = store_data;
                        end
                        s.sda   = s.shift_byte[s.bit_pos];
                        s.phase = PH_WR_SCL_HIGH;
                    end
                    PH_WR_SCL_HIGH, PH_RD_SCL_HIGH, PH_ACKGEN_SCL_HIGH,
                    PH_STOP_SCL_HIGH: begin
                        s.scl = 1'b1;
                        case (state_cur.phase)
                            PH_WR_SCL_HIGH:     s.phase = PH_WR_SCL_LOW;
                            PH_RD_SCL_HIGH:     s.phase = PH_RD_SCL_LOW;
                            PH_ACKGEN_SCL_HIGH: s.phase = PH_ACKGEN_SCL_LOW;
                            default:            s.phase = PH_STOP_SDA_HIGH;
                        endcase
                    end
                    PH_WR_SCL_LOW: begin
                        s.scl = 1'b0;
                        if (s.bit_pos != 3'd0) begin
                            s.bit_pos = s.bit_pos - 3'd1;
                            s.sda     = s.shift_byte[s.bit_pos];
                            s.phase   = PH_WR_SCL_HIGH;
                        end else begin
                            s.bit_pos = 3'd7;
                            s.sda     = 1'b1;
                            s.phase   = PH_ACKCHK_SCL_HIGH;
                        end
                    end
                    PH_RD_SCL_LOW: begin
                        s.scl = 1'b0;
                        if (s.bit_pos != 3'd0) begin
                            s.bit_pos = s.bit_pos - 3'd1;
                            if (item.sda_sample) begin
                                s.shift_byte[s.bit_pos] = 1'b1;
                            end
                            s.phase = PH_RD_SCL_HIGH;
                        end else begin
                            s.bit_pos = 3'd7;
                            // ACK every byte but the last
                            if (bp_inc_wide < {1'b0, s.xfer_len}) begin
                                s.sda = 1'b0;
                            end
                            s.phase = PH_ACKGEN_SCL_HIGH;
                        end
                    end
                    PH_ACKCHK_SCL_HIGH: begin
                        s.scl         = 1'b1;
                        s.ack_sampled = item.sda_sample;
                        s.phase       = PH_ACKCHK_SCL_LOW;
                    end
                    PH_ACKCHK_SCL_LOW, PH_ACKGEN_SCL_LOW: begin
                        s.scl = 1'b0;
                        if (s.sending_addr) begin
                            s.sending_addr = 1'b0;
                        end else begin
                            if (s.reading) begin
                                rv   = 1'b1;
                                ri   = s.byte_pos[3:0];
                                rval = s.shift_byte;
                            end
                            s.byte_pos = bp_inc;
                        end
                        if (s.reading) begin
                            if (s.byte_pos == s.xfer_len) begin
                                if (last_frame) begin
                                    s.sda   = 1'b0;
                                    s.phase = PH_STOP_SCL_HIGH;
                                end else begin
                                    s.sda   = 1'b1;
                                    ev      = EV_AVAILABLE;
                                    s.phase = PH_IDLE;
                                end
                            end else begin
                                s.sda        = 1'b1;
                                s.shift_byte = 8'd0;
                                if (item.sda_sample) begin
                                    s.shift_byte[s.bit_pos] = 1'b1;
                                end
                                s.phase = PH_RD_SCL_HIGH;
                            end
                        end else if (s.ack_sampled) begin
                            s.nack_seen = 1'b1;
                            s.sda       = 1'b0;
                            s.phase     = PH_STOP_SCL_HIGH;
                        end else if (s.byte_pos == s.xfer_len) begin
                            if (last_frame) begin
                                s.sda   = 1'b0;
                                s.phase = PH_STOP_SCL_HIGH;
                            end else begin
                                ev      = EV_WRITTEN;
                                s.phase = PH_IDLE;
                            end
                        end else begin
                            s.shift_byte = store_data;
                            s.sda        = s.shift_byte[s.bit_pos];
                            s.phase      = PH_WR_SCL_HIGH;
                        end
                    end
                    PH_STOP_SDA_HIGH: begin
                        s.sda = 1'b1;
                        if (s.nack_seen) begin
                            ev = EV_NACK;
                        end else if (s.reading) begin
                            ev = EV_AVAILABLE;
                        end else begin
                            ev = EV_WRITTEN;
                        end
                        s.phase = PH_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            OP_BEGIN_WRITE, OP_BEGIN_READ: begin
                if (state_cur.phase == PH_IDLE) begin
                    s.cur_frame = item.frame_kind;
                    s.xfer_len  = item.byte_count;
                    s.byte_pos  = 5'd0;
                    s.bit_pos   = 3'd7;
                    s.nack_seen = 1'b0;
                    s.reading   = is_read;
                    if (first || restart) begin
                        s.shift_byte   = {target_address, is_read};
                        s.sending_addr = 1'b1;
                        if (first) begin
                            s.sda   = 1'b0;
                            s.phase = PH_START_SCL_LOW;
                        end else begin
                            s.sda   = 1'b1;
                            s.scl   = 1'b0;
                            s.phase = PH_RESTART_SCL_HIGH;
                        end
                    end else if (is_read) begin
                        s.sda        = 1'b1;
                        s.shift_byte = {item.sda_sample, 7'd0};
                        s.phase      = PH_RD_SCL_HIGH;
                    end else begin
                        if (!s.sending_addr) begin
                            s.shift_byte = store_data;
                        end
                        s.sda   = s.shift_byte[s.bit_pos];
                        s.phase = PH_WR_SCL_HIGH;
                    end
                    s.prev_frame     = item.frame_kind;
                    s.prev_was_write = !is_read;
                end
            end
            OP_ABORT: begin
                s = SEQ_RESET;
            end
            default: begin
                // load beats only touch the buffer; other codes are no-ops
            end
        endcase

        state_next        = s;
        result.scl_level  = s.scl;
        result.sda_level  = s.sda;
        result.busy_res   = (s.phase != PH_IDLE);
        result.event_code = ev;
        result.read_valid = rv;
        result.read_index = ri;
        result.read_value = rval;
    end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the I2C master bit sequencer core.
// Depends on i2cmbs_pkg and i2c_master_bit_sequencer_core; a scoreboard class tracks the bus phases.
`timescale 1ns / 1ps

module testbench;
    import i2cmbs_pkg::*;

    // operation codes the block treats as no-ops
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    // APB byte address of the target address register
    localparam logic [2:0] REG_TARGET_ADDR = 3'd0;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // frame_kind[1:0], byte_count[6:2], load_index[10:7],
                            // load_value[18:11], sda_sample[19], zero pad [23:20]
    logic [2:0]  s_tuser;   // operation[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // scl_level[0], sda_level[1], busy_res[2], read_valid[3],
                            // read_index[7:4], read_value[15:8]
    logic [1:0]  m_tuser;   // event_code[1:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    i2c_master_bit_sequencer_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Tracks the sequencer phase by phase and holds the line levels still owed by the block.
    class i2c_seq_scoreboard;
        phase_t     ph;
        logic [2:0] bit_pos;
        logic [7:0] shreg;
        logic [4:0] byte_pos;
        logic [4:0] xfer_len;
        logic       addr_phase;
        logic [1:0] cur_frame;
        logic [1:0] prev_frame;
        logic       prev_write;
        logic       reading;
        logic       ack_bit;
        logic       nacked;
        logic       scl;
        logic       sda;
        logic [6:0] target;
        logic [7:0] wbuf [BUF_DEPTH];
        result_t    line_out;
        result_t    line_q[$];
        int         mismatches;

        function new();
            target = '0;
            foreach (wbuf[i]) wbuf[i] = '0;
            mismatches = 0;
            clear_seq();
        endfunction

        function void clear_seq();
            ph         = PH_IDLE;
            bit_pos    = 3'd7;
            shreg      = '0;
            byte_pos   = '0;
            xfer_len   = '0;
            addr_phase = 1'b0;
            cur_frame  = FRAME_FIRST_LAST;
            prev_frame = FRAME_FIRST_LAST;
            prev_write = 1'b0;
            reading    = 1'b0;
            ack_bit    = 1'b0;
            nacked     = 1'b0;
            scl        = 1'b1;
            sda        = 1'b1;
        endfunction

        function int pending();
            return line_q.size();
        endfunction

        function bit frame_ends_bus();
            return cur_frame == FRAME_LAST || cur_frame == FRAME_FIRST_LAST;
        endfunction

        function void put_bit();
            sda = shreg[bit_pos];
            ph  = PH_WR_SCL_HIGH;
        endfunction

        function void byte_out();
            if (!addr_phase) shreg = wbuf[byte_pos[3:0]];
            put_bit();
        endfunction

        function void take_bit(logic s);
            if (s) shreg[bit_pos] = 1'b1;
            ph = PH_RD_SCL_HIGH;
        endfunction

        function void byte_in(logic s);
            sda   = 1'b1;
            shreg = '0;
            take_bit(s);
        endfunction

        function void go_stop();
            sda = 1'b0;
            ph  = PH_STOP_SCL_HIGH;
        endfunction

        function void after_ack(logic s);
            if (addr_phase) begin
                addr_phase = 1'b0;
            end else begin
                if (reading) begin
                    line_out.read_valid = 1'b1;
                    line_out.read_index = byte_pos[3:0];
                    line_out.read_value = shreg;
                end
                byte_pos = byte_pos + 5'd1;
            end
            if (reading) begin
                if (byte_pos == xfer_len) begin
                    sda = 1'b1;
                    if (frame_ends_bus()) begin
                        go_stop();
                    end else begin
                        line_out.event_code = EV_AVAILABLE;
                        ph = PH_IDLE;
                    end
                end else begin
                    byte_in(s);
                end
            end else if (ack_bit) begin
                nacked = 1'b1;
                go_stop();
            end else if (byte_pos == xfer_len) begin
                if (frame_ends_bus()) begin
                    go_stop();
                end else begin
                    line_out.event_code = EV_WRITTEN;
                    ph = PH_IDLE;
                end
            end else begin
                byte_out();
            end
        endfunction

        function void tick(logic s);
            case (ph)
                PH_RESTART_SCL_HIGH: begin
                    scl = 1'b1;
                    ph  = PH_START_SDA_LOW;
                end
                PH_START_SDA_LOW: begin
                    sda = 1'b0;
                    ph  = PH_START_SCL_LOW;
                end
                PH_START_SCL_LOW: begin
                    scl = 1'b0;
                    byte_out();
                end
                PH_WR_SCL_HIGH: begin
                    scl = 1'b1;
                    ph  = PH_WR_SCL_LOW;
                end
                PH_WR_SCL_LOW: begin
                    scl = 1'b0;
                    if (bit_pos > 0) begin
                        bit_pos = bit_pos - 3'd1;
                        put_bit();
                    end else begin
                        bit_pos = 3'd7;
                        sda     = 1'b1;
                        ph      = PH_ACKCHK_SCL_HIGH;
                    end
                end
                PH_RD_SCL_HIGH: begin
                    scl = 1'b1;
                    ph  = PH_RD_SCL_LOW;
                end
                PH_RD_SCL_LOW: begin
                    scl = 1'b0;
                    if (bit_pos > 0) begin
                        bit_pos = bit_pos - 3'd1;
                        take_bit(s);
                    end else begin
                        bit_pos = 3'd7;
                        // master ACKs every byte but the last; no wrap in this compare
                        if ({1'b0, byte_pos} + 6'd1 < {1'b0, xfer_len}) sda = 1'b0;
                        ph = PH_ACKGEN_SCL_HIGH;
                    end
                end
                PH_ACKCHK_SCL_HIGH: begin
                    scl     = 1'b1;
                    ack_bit = s;
                    ph      = PH_ACKCHK_SCL_LOW;
                end
                PH_ACKGEN_SCL_HIGH: begin
                    scl = 1'b1;
                    ph  = PH_ACKGEN_SCL_LOW;
                end
                PH_ACKCHK_SCL_LOW, PH_ACKGEN_SCL_LOW: begin
                    scl = 1'b0;
                    after_ack(s);
                end
                PH_STOP_SCL_HIGH: begin
                    scl = 1'b1;
                    ph  = PH_STOP_SDA_HIGH;
                end
                PH_STOP_SDA_HIGH: begin
                    sda = 1'b1;
                    line_out.event_code = nacked ? EV_NACK : (reading ? EV_AVAILABLE : EV_WRITTEN);
                    ph = PH_IDLE;
                end
                default: ;
            endcase
        endfunction

        function void open_transfer(logic is_read, logic [1:0] frame, logic [4:0] count,
                                    logic s);
            logic first;
            logic restart;
            first   = (frame == FRAME_FIRST || frame == FRAME_FIRST_LAST);
            restart = is_read && prev_write &&
                      (prev_frame == FRAME_FIRST || prev_frame == FRAME_NEXT);
            cur_frame = frame;
            xfer_len  = count;
            byte_pos  = '0;
            bit_pos   = 3'd7;
            nacked    = 1'b0;
            reading   = is_read;
            if (first || restart) begin
                shreg      = {target, is_read};
                addr_phase = 1'b1;
                if (first) begin
                    sda = 1'b0;
                    ph  = PH_START_SCL_LOW;
                end else begin
                    sda = 1'b1;
                    scl = 1'b0;
                    ph  = PH_RESTART_SCL_HIGH;
                end
            end else if (is_read) begin
                byte_in(s);
            end else begin
                byte_out();
            end
            prev_frame = frame;
            prev_write = !is_read;
        endfunction

        // accepted command beat: advance the model and queue the line levels it yields
        function void note_cmd(item_t it);
            line_out = '0;
            case (it.operation)
                OP_TICK: tick(it.sda_sample);
                OP_BEGIN_WRITE, OP_BEGIN_READ: begin
                    if (ph == PH_IDLE)
                        open_transfer(it.operation == OP_BEGIN_READ, it.frame_kind,
                                      it.byte_count, it.sda_sample);
                end
                OP_LOAD:  wbuf[it.load_index] = it.load_value;
                OP_ABORT: clear_seq();
                default: ;
            endcase
            line_out.scl_level = scl;
            line_out.sda_level = sda;
            line_out.busy_res  = (ph != PH_IDLE);
            line_q.push_back(line_out);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (line_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing outstanding: %h", $realtime, got);
                return;
            end
            want = line_q.pop_front();
            if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
                got.busy_res !== want.busy_res || got.event_code !== want.event_code ||
                got.read_valid !== want.read_valid || got.read_index !== want.read_index ||
                got.read_value !== want.read_value) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch exp scl=%b sda=%b busy=%b ev=%0d rv=%b ri=%0d rd=%h",
                             $realtime, want.scl_level, want.sda_level, want.busy_res,
                             want.event_code, want.read_valid, want.read_index,
                             want.read_value);
                    $display("%0t:          got scl=%b sda=%b busy=%b ev=%0d rv=%b ri=%0d rd=%h",
                             $realtime, got.scl_level, got.sda_level, got.busy_res,
                             got.event_code, got.read_valid, got.read_index, got.read_value);
                end
            end
        endfunction
    endclass

    i2c_seq_scoreboard scb = new();

    int sent;
    int hold_cycles;
    bit quiet_src;
    bit quiet_snk;
    bit src_on;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("** i2c_master_bit_sequencer_core: FAILED **");
        $finish;
    end

    function automatic item_t rand_item();
        item_t it;
        it.operation  = 3'($urandom_range(0, 7));
        it.frame_kind = 2'($urandom_range(0, 3));
        it.byte_count = 5'($urandom_range(0, 16));
        it.load_index = 4'($urandom_range(0, 15));
        it.load_value = 8'($urandom_range(0, 255));
        it.sda_sample = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic logic [4:0] pick_count(logic [1:0] frame);
        int r;
        r = $urandom_range(0, 99);
        // count 0 only where an address byte goes first: elsewhere it means 32 bytes
        if (r < 8)  return (frame == FRAME_FIRST || frame == FRAME_FIRST_LAST) ? 5'd0 : 5'd1;
        if (r < 75) return 5'($urandom_range(1, 2));
        if (r < 93) return 5'($urandom_range(3, 6));
        if (r < 98) return 5'($urandom_range(7, 15));
        return 5'd16;
    endfunction

    task automatic push_cmd(input item_t it);
        int gap;
        s_tvalid <= 1'b1;
        src_on   = 1'b1;
        s_tuser  <= it.operation;
        s_tdata  <= {4'b0, it.sda_sample, it.load_value, it.load_index, it.byte_count,
                     it.frame_kind};
        do @(posedge aclk); while (!s_tready);
        scb.note_cmd(it);
        sent++;
        gap = quiet_src ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            src_on   = 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic stop_src();
        if (src_on) begin
            s_tvalid <= 1'b0;
            src_on   = 1'b0;
        end
    endtask

    task automatic drain();
        stop_src();
        do @(posedge aclk); while (scb.pending() != 0);
    endtask

    task automatic cfg_write(input logic [6:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TARGET_ADDR;
        pwdata  <= ($urandom() & 32'hFFFF_FF80) | {25'd0, addr};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        scb.target = addr;
    endtask

    // bring the sequencer to rest, then change the target address
    task automatic retarget(input logic [6:0] addr);
        item_t it;
        drain();
        if (scb.ph != PH_IDLE) begin
            it = rand_item();
            it.operation = OP_ABORT;
            push_cmd(it);
            drain();
        end
        repeat (4) @(posedge aclk);
        cfg_write(addr);
    endtask

    // one begin beat followed by ticks (mixed with other commands unless clean) until the sequencer goes idle again
    task automatic run_transfer(input logic [2:0] op, input logic [1:0] frame,
                                input logic [4:0] count, input bit clean);
        item_t it;
        int r;
        it = rand_item();
        it.operation  = op;
        it.frame_kind = frame;
        it.byte_count = count;
        push_cmd(it);
        while (scb.ph != PH_IDLE) begin
            it = rand_item();
            r  = clean ? 0 : $urandom_range(0, 999);
            if (r < 920 || r >= 983) begin
                it.operation = OP_TICK;
                if (scb.ph == PH_ACKCHK_SCL_HIGH)
                    it.sda_sample = clean ? 1'b0 : ($urandom_range(0, 7) == 0);
            end else if (r < 940) begin
                it.operation = OP_LOAD;
            end else if (r < 960) begin
                // begin while busy: must be ignored
                it.operation = $urandom_range(0, 1) ? OP_BEGIN_READ : OP_BEGIN_WRITE;
            end else if (r < 980) begin
                it.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end else begin
                it.operation = OP_ABORT;
            end
            push_cmd(it);
        end
    endtask

    task automatic idle_noise();
        item_t it;
        it = rand_item();
        case ($urandom_range(0, 3))
            0: it.operation = OP_TICK;
            1: it.operation = OP_LOAD;
            2: it.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            default: it.operation = OP_ABORT;
        endcase
        push_cmd(it);
    endtask

    task automatic random_traffic(input int n_items);
        int stop_at;
        logic [1:0] frame;
        stop_at = sent + n_items;
        while (sent < stop_at) begin
            repeat ($urandom_range(0, 2)) idle_noise();
            frame = 2'($urandom_range(0, 3));
            run_transfer($urandom_range(0, 1) ? OP_BEGIN_READ : OP_BEGIN_WRITE, frame,
                         pick_count(frame), 1'b0);
        end
    endtask

    task automatic directed_items();
        item_t it;
        // fill the whole write buffer so no unloaded slot is ever sent
        for (int i = 0; i < BUF_DEPTH; i++) begin
            it = rand_item();
            it.operation  = OP_LOAD;
            it.load_index = 4'(i);
            if (i == 0)
                it.load_value = 8'h00;
            else if (i == BUF_DEPTH - 1)
                it.load_value = 8'hFF;
            push_cmd(it);
        end
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) begin
            it = rand_item();
            it.operation = 3'(op);
            push_cmd(it);
        end
        it = rand_item();
        it.operation = OP_TICK;
        push_cmd(it);
        it.operation = OP_ABORT;
        push_cmd(it);
        it = rand_item();
        it.operation  = OP_BEGIN_WRITE;
        it.frame_kind = FRAME_FIRST;
        it.byte_count = 5'd16;
        push_cmd(it);
        it = rand_item();
        it.operation = OP_BEGIN_READ;
        push_cmd(it);
        repeat (2) begin
            it = rand_item();
            it.operation = OP_TICK;
            push_cmd(it);
        end
        it.operation = OP_ABORT;
        push_cmd(it);
    endtask

    // result side: random stalls, plus a long hold-off when asked for
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = quiet_snk ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            scb.check_result('{scl_level:  m_tdata[0],
                               sda_level:  m_tdata[1],
                               busy_res:   m_tdata[2],
                               event_code: m_tuser,
                               read_valid: m_tdata[3],
                               read_index: m_tdata[7:4],
                               read_value: m_tdata[15:8]});
        end
    end

    initial begin
        sent        = 0;
        hold_cycles = 0;
        quiet_src   = 1'b0;
        quiet_snk   = 1'b0;
        src_on      = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_TICK;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= REG_TARGET_ADDR;
        pwdata   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cfg_write(7'h7F);
        directed_items();
        random_traffic(200);

        retarget(7'h00);
        // long receiver hold-off while commands keep coming back to back
        hold_cycles = 300;
        quiet_src   = 1'b1;
        random_traffic(40);
        quiet_snk   = 1'b1;
        random_traffic(100);
        quiet_src   = 1'b0;
        quiet_snk   = 1'b0;
        random_traffic(100);

        retarget(7'($urandom_range(1, 126)));
        random_traffic(100);

        drain();
        repeat (10) @(posedge aclk);
        if (scb.mismatches == 0 && scb.pending() == 0)
            $display("** i2c_master_bit_sequencer_core: PASSED **");
        else
            $display("** i2c_master_bit_sequencer_core: FAILED **");
        $finish;
    end

endmodule
